// ===== rtl/core/sapd_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial API frame deframer package
// Shared constants, codes, configuration and result types.
// ----------------------------------------------------------------------------
package sapd_pkg;

    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] SUM_GOOD   = 8'hFF;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_LEN  = 2'd0;
    localparam logic [1:0] CFG_CMD_CODE = 2'd1;
    localparam logic [1:0] CFG_TX_CODE  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_MAX_LEN  = 8'd128;
    localparam logic [7:0] RST_CMD_CODE = 8'd8;
    localparam logic [7:0] RST_TX_CODE  = 8'd1;

    // Frame classes.
    localparam logic [1:0] CLASS_COMMAND  = 2'd0;
    localparam logic [1:0] CLASS_TRANSMIT = 2'd1;
    localparam logic [1:0] CLASS_OTHER    = 2'd2;

    // Frame status codes.
    localparam logic [1:0] STATUS_GOOD   = 2'd0;
    localparam logic [1:0] STATUS_BAD    = 2'd1;
    localparam logic [1:0] STATUS_LENGTH = 2'd2;

    typedef struct packed {
        logic [7:0] max_frame_length;
        logic [7:0] command_type_code;
        logic [7:0] transmit_type_code;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_type;
        logic [1:0] frame_class;
        logic       end_of_frame;
        logic [1:0] frame_status;
    } t_result;

    // A type byte matching both codes counts as a command frame.
    function automatic logic [1:0] classify(input logic [7:0] frm_type, input t_cfg cfg);
        logic [1:0] cls;
        if (frm_type == cfg.command_type_code) begin
            cls = CLASS_COMMAND;
        end else if (frm_type == cfg.transmit_type_code) begin
            cls = CLASS_TRANSMIT;
        end else begin
            cls = CLASS_OTHER;
        end
        return cls;
    endfunction

endpackage

// ===== rtl/core/sapd_if.sv =====
// ----------------------------------------------------------------------------
// Serial API frame deframer channels
// Valid/ready channels for received bytes and for deframed results.
// ----------------------------------------------------------------------------
interface sapd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sapd_frm_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_type;
    logic [1:0] frame_class;
    logic       end_of_frame;
    logic [1:0] frame_status;

    modport source (output valid, output data_byte, output byte_index, output frame_type,
                    output frame_class, output end_of_frame, output frame_status,
                    input ready);
    modport sink   (input valid, input data_byte, input byte_index, input frame_type,
                    input frame_class, input end_of_frame, input frame_status,
                    output ready);
endinterface

// ===== rtl/core/sapd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the length limit and the two type codes, written by index.
// ----------------------------------------------------------------------------
module sapd_cfg_regs
    import sapd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_frame_length   <= RST_MAX_LEN;
            r_cfg.command_type_code  <= RST_CMD_CODE;
            r_cfg.transmit_type_code <= RST_TX_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_LEN:  r_cfg.max_frame_length   <= i_cfg_data;
                CFG_CMD_CODE: r_cfg.command_type_code  <= i_cfg_data;
                CFG_TX_CODE:  r_cfg.transmit_type_code <= i_cfg_data;
                default: begin
                    // Unused index: the write is dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/sapd_parse.sv =====
// ----------------------------------------------------------------------------
// Frame parser
// Input byte register, frame state and the one-byte parsing step.
// ----------------------------------------------------------------------------
module sapd_parse
    import sapd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_in_ready,
    input  t_cfg       i_cfg,
    input  logic       i_res_ready,
    output logic       o_res_valid,
    output t_result    o_res
);

    typedef enum logic [1:0] {
        STEP_LEN_HI,
        STEP_LEN_LO,
        STEP_TYPE,
        STEP_PAYLOAD
    } t_step;

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic       r_in_frame, n_in_frame;
    t_step      r_step, n_step;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_len, n_len;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_type, n_type;

    logic       res_valid;
    t_result    res;
    logic       fire;
    logic [7:0] total;
    logic       last_byte;

    assign total     = r_sum + r_in_byte;
    assign last_byte = ({1'b0, r_pos} + 9'd1) >= {1'b0, r_len};

    always_comb begin
        n_in_frame = r_in_frame;
        n_step     = r_step;
        n_pos      = r_pos;
        n_len      = r_len;
        n_sum      = r_sum;
        n_type     = r_type;
        res_valid  = 1'b0;
        res        = '0;

        if (!r_in_frame) begin
            if (r_in_byte == START_BYTE) begin
                n_in_frame = 1'b1;
                n_step     = STEP_LEN_HI;
                n_pos      = '0;
                n_len      = '0;
                n_sum      = '0;
                n_type     = '0;
            end
        end else begin
            unique case (r_step)
                STEP_LEN_HI: begin
                    n_step = STEP_LEN_LO;
                end
                STEP_LEN_LO: begin
                    n_len = r_in_byte;
                    if (r_in_byte == 8'd0 || r_in_byte > i_cfg.max_frame_length) begin
                        n_in_frame       = 1'b0;
                        n_step           = STEP_LEN_HI;
                        res_valid        = 1'b1;
                        res.frame_class  = CLASS_OTHER;
                        res.end_of_frame = 1'b1;
                        res.frame_status = STATUS_LENGTH;
                    end else begin
                        n_step = STEP_TYPE;
                    end
                end
                STEP_TYPE: begin
                    n_type = r_in_byte;
                    n_sum  = total;
                    n_pos  = '0;
                    n_step = STEP_PAYLOAD;
                end
                STEP_PAYLOAD: begin
                    res_valid       = 1'b1;
                    res.byte_index  = r_pos;
                    res.frame_type  = r_type;
                    res.frame_class = classify(r_type, i_cfg);
                    if (last_byte) begin
                        // Checksum byte closes the frame.
                        n_in_frame       = 1'b0;
                        n_step           = STEP_LEN_HI;
                        res.end_of_frame = 1'b1;
                        res.frame_status = (total == SUM_GOOD) ? STATUS_GOOD : STATUS_BAD;
                    end else begin
                        res.data_byte    = r_in_byte;
                        res.frame_status = STATUS_GOOD;
                        n_sum            = total;
                        n_pos            = r_pos + 8'd1;
                    end
                end
                default: begin
                    n_step = STEP_LEN_HI;
                end
            endcase
        end
    end

    // A held byte moves on once its result, if any, has room downstream.
    assign fire       = r_in_valid && (!res_valid || i_res_ready);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_in_frame <= 1'b0;
            r_step     <= STEP_LEN_HI;
            r_pos      <= '0;
            r_len      <= '0;
            r_sum      <= '0;
            r_type     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_in_frame <= n_in_frame;
                r_step     <= n_step;
                r_pos      <= n_pos;
                r_len      <= n_len;
                r_sum      <= n_sum;
                r_type     <= n_type;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    assign o_res_valid = r_in_valid && res_valid;
    assign o_res       = res;

    a_close_leaves_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && res_valid && res.end_of_frame |=> !r_in_frame)
        else $error("frame still open after closing result");

    a_length_item_shape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && res_valid && res.frame_status == STATUS_LENGTH
        |-> res.end_of_frame && res.frame_type == 8'd0 && res.byte_index == 8'd0)
        else $error("malformed length-invalid result");

    a_pos_below_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame && r_step == STEP_PAYLOAD |-> r_pos < r_len)
        else $error("payload index ran past frame length");

    a_hunt_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> r_step == STEP_LEN_HI)
        else $error("header step not rewound while hunting");

endmodule

// ===== rtl/core/sapd_out_reg.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one result transfer until the downstream side takes it.
// ----------------------------------------------------------------------------
module sapd_out_reg
    import sapd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_ready
);

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/core/serial_api_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// Serial API frame deframer
// Path: a byte is held in the input byte register while it is parsed, and its
//   result transfer is offered on the output from the result register.
// Throughput: one byte per cycle while the result register has room, set by
//   the parsing step between the input byte register and the result register.
// Reset: synchronous, active low; the parser returns to hunting for the start
//   byte and the registers return to their default values.
// ----------------------------------------------------------------------------
module serial_api_frame_deframer
    import sapd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sapd_rx_if.sink    i_rx,
    sapd_frm_if.source o_frm,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // Configuration values shared with the parser.
    t_cfg    cfg;

    // Parser to result register handshake.
    logic    res_valid;
    logic    res_ready;
    t_result res;

    // Result register contents as presented on the output channel.
    t_result out_res;

    // The three registers: length limit, command code and transmit code.
    sapd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The parser registers each received byte, then in one step advances the
    // frame state and forms at most one result. Hunted bytes and accepted header
    // bytes never wait on the output; payload, closing and rejected length bytes
    // wait only for room in the result register.
    sapd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx.valid),
        .i_rx_byte   (i_rx.rx_byte),
        .o_in_ready  (i_rx.ready),
        .i_cfg       (cfg),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // The result register separates the two sides, so a new byte can be
    // taken while a finished result still waits for its transfer.
    sapd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (res_ready),
        .o_valid (o_frm.valid),
        .o_res   (out_res),
        .i_ready (o_frm.ready)
    );

    assign o_frm.data_byte    = out_res.data_byte;
    assign o_frm.byte_index   = out_res.byte_index;
    assign o_frm.frame_type   = out_res.frame_type;
    assign o_frm.frame_class  = out_res.frame_class;
    assign o_frm.end_of_frame = out_res.end_of_frame;
    assign o_frm.frame_status = out_res.frame_status;

endmodule
